// ===== sv/cxu_pkg.sv =====
// cxu_pkg: shared types and constants for the four-channel crosstalk unmix block.
// No dependencies; used by cxu_recip, cxu_lane and four_channel_crosstalk_unmix.
package cxu_pkg;

	localparam int SLOPE_W    = 16;
	localparam int RECIP_W    = 32;
	localparam int RECIP_FRAC = 16;
	localparam int CFG_IDX_W  = 8;

	localparam logic [RECIP_W-1:0] RECIP_MAX = 32'h7FFF_FFFF;
	localparam logic [RECIP_W-1:0] RECIP_ONE = 32'h0001_0000;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_AC = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CA = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GT = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TG = 8'd3;

	// per-stage load enables, one per pipeline register
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
	} stage_en_t;

endpackage

// ===== sv/cxu_recip.sv =====
// cxu_recip: sequential reciprocal of a 2x2 determinant, 1 / (1 - s1*s2).
// Restoring divider, one quotient bit per cycle. Depends on cxu_pkg.
module cxu_recip #(
	parameter int SLOPE_FRAC_BITS = 14
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	input  logic signed [cxu_pkg::SLOPE_W-1:0]   slope1,
	input  logic signed [cxu_pkg::SLOPE_W-1:0]   slope2,
	output logic signed [cxu_pkg::RECIP_W-1:0]   recip,
	output logic                                 busy
);

	localparam int F2 = 2 * SLOPE_FRAC_BITS;
	// determinant needs room for 2^(2F) plus a full slope product
	localparam int DW = ((F2 > 30) ? F2 : 30) + 2;
	localparam int RW = DW + 1;
	localparam int K  = F2 + cxu_pkg::RECIP_FRAC;
	localparam int CW = $clog2(K + 1);
	localparam int QW = cxu_pkg::RECIP_W - 1;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_PREP = 3'b010,
		ST_DIV  = 3'b100
	} recip_state_t;

	recip_state_t state_q;
	logic [CW-1:0] cnt_q;
	logic [DW-1:0] dmag_q;
	logic          dneg_q;
	logic [DW-1:0] r_q;
	logic [QW-1:0] q_q;
	logic          ovf_q;
	logic signed [cxu_pkg::RECIP_W-1:0] recip_q;

	logic signed [31:0]   prod;
	logic signed [DW-1:0] det;
	logic [DW-1:0]        det_abs;
	logic [RW-1:0]        r_sh;
	logic [RW-1:0]        r_nx;
	logic                 ge;
	logic [QW-1:0]        q_nx;
	logic                 ovf_nx;
	logic [cxu_pkg::RECIP_W-1:0] mag32;

	always_comb begin
		prod    = slope1 * slope2;
		det     = (DW'(1) <<< F2) - DW'(prod);
		det_abs = det[DW-1] ? DW'(-det) : DW'(det);
		r_sh    = {r_q, (cnt_q == CW'(K))};
		ge      = (r_sh >= {1'b0, dmag_q});
		r_nx    = ge ? (r_sh - {1'b0, dmag_q}) : r_sh;
		q_nx    = {q_q[QW-2:0], ge};
		// once bit 30 is set the next shift passes 2^31-1: clamp sticks
		ovf_nx  = ovf_q | q_q[QW-1];
		mag32   = ovf_nx ? cxu_pkg::RECIP_MAX : {1'b0, q_nx};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			recip_q <= cxu_pkg::RECIP_ONE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_PREP;
					end
				end
				ST_PREP: begin
					cnt_q   <= CW'(K);
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (cnt_q == '0) begin
						state_q <= ST_IDLE;
						if (dmag_q == '0) begin
							recip_q <= '0;
						end else begin
							recip_q <= dneg_q ? -$signed(mag32) : $signed(mag32);
						end
					end else begin
						cnt_q <= cnt_q - CW'(1);
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_PREP) begin
			dmag_q <= det_abs;
			dneg_q <= det[DW-1];
			r_q    <= '0;
			q_q    <= '0;
			ovf_q  <= 1'b0;
		end else if (state_q == ST_DIV) begin
			r_q   <= r_nx[DW-1:0];
			q_q   <= q_nx;
			ovf_q <= ovf_nx;
		end
	end

	assign recip = recip_q;
	assign busy  = (state_q != ST_IDLE);

	a_start_prep: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && start) |=> (state_q == ST_PREP))
		else $error("recip: start did not enter prep");

	a_div_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV && cnt_q == '0) |=> (state_q == ST_IDLE))
		else $error("recip: divider overran its count");

endmodule

// ===== sv/cxu_lane.sv =====
// cxu_lane: four-stage datapath for one corrected channel, v * (x*2^F - s*y).
// Round half away from zero, saturate to the sample width. Depends on cxu_pkg.
module cxu_lane #(
	parameter int SAMPLE_WIDTH    = 16,
	parameter int SLOPE_FRAC_BITS = 14
) (
	input  logic                                 clk,
	input  cxu_pkg::stage_en_t                   en,
	input  logic signed [SAMPLE_WIDTH-1:0]       x,
	input  logic signed [SAMPLE_WIDTH-1:0]       y,
	input  logic signed [cxu_pkg::SLOPE_W-1:0]   slope,
	input  logic signed [cxu_pkg::RECIP_W-1:0]   recip,
	output logic signed [SAMPLE_WIDTH-1:0]       value,
	output logic                                 sat
);

	localparam int SW  = SAMPLE_WIDTH;
	localparam int PYW = cxu_pkg::SLOPE_W + SW;
	localparam int XW  = SW + SLOPE_FRAC_BITS;
	localparam int IW  = ((PYW > XW) ? PYW : XW) + 1;
	localparam int RMW = cxu_pkg::RECIP_W - 1;
	localparam int MW  = (IW - 1) + RMW;
	localparam int S   = SLOPE_FRAC_BITS + cxu_pkg::RECIP_FRAC;

	localparam logic [MW:0] HALF = (MW + 1)'(1) << (S - 1);
	localparam logic [MW:0] LIM  = (MW + 1)'(1) << (SW - 1);

	// stage 1: slope product
	logic signed [PYW-1:0] sy_s1;
	logic signed [SW-1:0]  x_s1;
	// stage 2: inner term as sign and magnitude
	logic [IW-2:0]         mag_s2;
	logic                  neg_s2;
	// stage 3: magnitude times reciprocal
	logic [MW-1:0]         prod_s3;
	logic                  neg_s3;
	// stage 4: result
	logic signed [SW-1:0]  value_s4;
	logic                  sat_s4;

	logic signed [IW-1:0] inner;
	logic [IW-1:0]        inner_abs;
	logic [RMW-1:0]       rmag;
	logic [MW:0]          rnd;
	logic [MW:0]          mag;
	logic                 clip;
	logic [SW-1:0]        mag_lo;
	logic [SW-1:0]        val_nx;

	always_comb begin
		inner     = (IW'(x_s1) <<< SLOPE_FRAC_BITS) - IW'(sy_s1);
		inner_abs = inner[IW-1] ? IW'(-inner) : IW'(inner);
		rmag      = recip[cxu_pkg::RECIP_W-1] ? RMW'(-recip) : RMW'(recip);
		rnd       = {1'b0, prod_s3} + HALF;
		mag       = rnd >> S;
		clip      = neg_s3 ? (mag > LIM) : (mag > (LIM - (MW + 1)'(1)));
		mag_lo    = mag[SW-1:0];
		if (clip) begin
			val_nx = neg_s3 ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
		end else begin
			val_nx = neg_s3 ? (-mag_lo) : mag_lo;
		end
	end

	always_ff @(posedge clk) begin
		if (en.s1) begin
			sy_s1 <= slope * y;
			x_s1  <= x;
		end
		if (en.s2) begin
			mag_s2 <= inner_abs[IW-2:0];
			neg_s2 <= inner[IW-1];
		end
		if (en.s3) begin
			prod_s3 <= MW'(mag_s2) * MW'(rmag);
			neg_s3  <= neg_s2 ^ recip[cxu_pkg::RECIP_W-1];
		end
		if (en.s4) begin
			value_s4 <= val_nx;
			sat_s4   <= clip;
		end
	end

	assign value = value_s4;
	assign sat   = sat_s4;

endmodule

// ===== sv/four_channel_crosstalk_unmix.sv =====
// four_channel_crosstalk_unmix: A/C and G/T 2x2 crosstalk unmixing over 4 lanes.
// Input beats pass stages s1 to s4 to the output; throughput 1 beat/cycle while
// out_ready is high and no refresh runs. A slope write reloads both reciprocals
// through the serial dividers, with in_ready and cfg_ready low meanwhile.
// Reset: slopes 0, reciprocals 1.0 (Q15.16), pipeline empty. No clearing pass.
// Depends on cxu_pkg, cxu_recip, cxu_lane.
module four_channel_crosstalk_unmix #(
	parameter int SAMPLE_WIDTH    = 16,
	parameter int SLOPE_FRAC_BITS = 14
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// input channel
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic signed [SAMPLE_WIDTH-1:0]        a_in,
	input  logic signed [SAMPLE_WIDTH-1:0]        c_in,
	input  logic signed [SAMPLE_WIDTH-1:0]        g_in,
	input  logic signed [SAMPLE_WIDTH-1:0]        t_in,
	// output channel
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic signed [SAMPLE_WIDTH-1:0]        a_out,
	output logic signed [SAMPLE_WIDTH-1:0]        c_out,
	output logic signed [SAMPLE_WIDTH-1:0]        g_out,
	output logic signed [SAMPLE_WIDTH-1:0]        t_out,
	output logic [1:0]                            singular_flag,
	output logic                                  saturated_flag,
	// configuration write channel
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [cxu_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [cxu_pkg::SLOPE_W-1:0]           cfg_data
);

	// slope registers
	logic signed [cxu_pkg::SLOPE_W-1:0] ac_q, ca_q, gt_q, tg_q;

	logic cfg_fire;
	logic cfg_hit;
	logic in_fire;

	// reciprocal units
	logic signed [cxu_pkg::RECIP_W-1:0] recip_ac, recip_gt;
	logic busy_ac, busy_gt, busy_any;

	// pipeline valid bits and per-stage enables
	logic v_s1, v_s2, v_s3, v_s4;
	cxu_pkg::stage_en_t en;
	logic [1:0] singular_s4;

	logic sat_a, sat_c, sat_g, sat_t;

	assign busy_any  = busy_ac | busy_gt;
	assign cfg_ready = ~busy_any;
	assign cfg_fire  = cfg_valid & cfg_ready;

	// a stage loads when empty or when the one after it moves on
	always_comb begin
		en.s4 = ~v_s4 | out_ready;
		en.s3 = ~v_s3 | en.s4;
		en.s2 = ~v_s2 | en.s3;
		en.s1 = ~v_s1 | en.s2;
	end

	// no beat is taken while the reciprocals are stale
	assign in_ready = en.s1 & ~busy_any;
	assign in_fire  = in_valid & in_ready;

	// register decode; an index past the list is dropped and starts no refresh
	always_comb begin
		unique case (cfg_index)
			cxu_pkg::REG_AC, cxu_pkg::REG_CA,
			cxu_pkg::REG_GT, cxu_pkg::REG_TG: cfg_hit = 1'b1;
			default:                          cfg_hit = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ac_q <= '0;
			ca_q <= '0;
			gt_q <= '0;
			tg_q <= '0;
		end else if (cfg_fire) begin
			unique case (cfg_index)
				cxu_pkg::REG_AC: ac_q <= cfg_data;
				cxu_pkg::REG_CA: ca_q <= cfg_data;
				cxu_pkg::REG_GT: gt_q <= cfg_data;
				cxu_pkg::REG_TG: tg_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// both reciprocals restart on any slope write; the unchanged one
	// simply recomputes the same value
	cxu_recip #(
		.SLOPE_FRAC_BITS(SLOPE_FRAC_BITS)
	) u_recip_ac (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cfg_fire & cfg_hit),
		.slope1 (ac_q),
		.slope2 (ca_q),
		.recip  (recip_ac),
		.busy   (busy_ac)
	);

	cxu_recip #(
		.SLOPE_FRAC_BITS(SLOPE_FRAC_BITS)
	) u_recip_gt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cfg_fire & cfg_hit),
		.slope1 (gt_q),
		.slope2 (tg_q),
		.recip  (recip_gt),
		.busy   (busy_gt)
	);

	// valid bits follow the data through the stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en.s1) v_s1 <= in_fire;
			if (en.s2) v_s2 <= v_s1;
			if (en.s3) v_s3 <= v_s2;
			if (en.s4) v_s4 <= v_s3;
		end
	end

	// a zero reciprocal marks a singular pair
	always_ff @(posedge clk) begin
		if (en.s4) begin
			singular_s4 <= {(recip_gt == '0), (recip_ac == '0)};
		end
	end

	// A uses the C->A slope, C the A->C slope; G/T likewise
	cxu_lane #(
		.SAMPLE_WIDTH   (SAMPLE_WIDTH),
		.SLOPE_FRAC_BITS(SLOPE_FRAC_BITS)
	) u_lane_a (
		.clk(clk), .en(en), .x(a_in), .y(c_in), .slope(ca_q), .recip(recip_ac),
		.value(a_out), .sat(sat_a)
	);

	cxu_lane #(
		.SAMPLE_WIDTH   (SAMPLE_WIDTH),
		.SLOPE_FRAC_BITS(SLOPE_FRAC_BITS)
	) u_lane_c (
		.clk(clk), .en(en), .x(c_in), .y(a_in), .slope(ac_q), .recip(recip_ac),
		.value(c_out), .sat(sat_c)
	);

	cxu_lane #(
		.SAMPLE_WIDTH   (SAMPLE_WIDTH),
		.SLOPE_FRAC_BITS(SLOPE_FRAC_BITS)
	) u_lane_g (
		.clk(clk), .en(en), .x(g_in), .y(t_in), .slope(tg_q), .recip(recip_gt),
		.value(g_out), .sat(sat_g)
	);

	cxu_lane #(
		.SAMPLE_WIDTH   (SAMPLE_WIDTH),
		.SLOPE_FRAC_BITS(SLOPE_FRAC_BITS)
	) u_lane_t (
		.clk(clk), .en(en), .x(t_in), .y(g_in), .slope(gt_q), .recip(recip_gt),
		.value(t_out), .sat(sat_t)
	);

	assign out_valid      = v_s4;
	assign singular_flag  = singular_s4;
	assign saturated_flag = sat_a | sat_c | sat_g | sat_t;

	a_no_beat_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |-> !busy_any)
		else $error("input beat taken during reciprocal refresh");

	a_write_starts_refresh: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_valid && cfg_ready && cfg_hit) |=> busy_ac && busy_gt)
		else $error("slope write did not start a refresh");

	a_stage_moves: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && en.s2) |=> v_s2)
		else $error("beat lost between stage 1 and stage 2");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && !en.s3) |=> v_s3 && v_s4)
		else $error("stalled stage 3 beat dropped");

endmodule
